FILE: rtl/gars_pkg.sv
package gars_pkg;

  localparam int unsigned DATA_W = 16;

  // Bus command bytes
  localparam logic [7:0] CMD_COLUMN_ADDR  = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR     = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;

  // Input word command codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Register select codes
  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  // Config register indexes
  localparam logic [1:0] REG_GRID_SPACING = 2'd0;
  localparam logic [1:0] REG_LINE_COLOR   = 2'd1;
  localparam logic [1:0] REG_BACK_COLOR   = 2'd2;

  localparam logic [DATA_W-1:0] GRID_SPACING_RST = 16'd40;
  localparam logic [DATA_W-1:0] LINE_COLOR_RST   = 16'd13894;
  localparam logic [DATA_W-1:0] BACK_COLOR_RST   = 16'd0;

  // Header sequence positions
  localparam logic [3:0] HDR_COL_CMD   = 4'd0;
  localparam logic [3:0] HDR_LEFT_HI   = 4'd1;
  localparam logic [3:0] HDR_LEFT_LO   = 4'd2;
  localparam logic [3:0] HDR_RIGHT_HI  = 4'd3;
  localparam logic [3:0] HDR_RIGHT_LO  = 4'd4;
  localparam logic [3:0] HDR_ROW_CMD   = 4'd5;
  localparam logic [3:0] HDR_TOP_HI    = 4'd6;
  localparam logic [3:0] HDR_TOP_LO    = 4'd7;
  localparam logic [3:0] HDR_BOTTOM_HI = 4'd8;
  localparam logic [3:0] HDR_BOTTOM_LO = 4'd9;
  localparam logic [3:0] HDR_MEM_CMD   = 4'd10;
  localparam logic [3:0] HDR_LEN       = 4'd11;

  typedef struct packed {
    logic              command;
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] box_width;
    logic [DATA_W-1:0] box_height;
  } in_word_t;

  typedef struct packed {
    logic       register_select;
    logic [7:0] bus_byte;
    logic       last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load_start;
    logic rem_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic in_header;
    logic rem_busy;
  } dp_status_t;

endpackage

FILE: rtl/gars_mod.sv
module gars_mod #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [COORD_BITS-1:0]         a_i,
  input  logic [COORD_BITS-1:0]         b_i,
  input  logic [gars_pkg::DATA_W-1:0]   divisor_i,
  output logic                          busy_o,
  output logic                          a_zero_o,
  output logic                          b_zero_o
);
  import gars_pkg::*;

  localparam int unsigned CNT_W  = $clog2(COORD_BITS + 1);
  localparam int unsigned WIDE_W = DATA_W + 1;

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [COORD_BITS-1:0] a_sh_q, a_sh_d, b_sh_q, b_sh_d;
  logic [COORD_BITS-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [DATA_W-1:0]     div_q, div_d;

  // One restoring step: shift in next dividend bit, subtract if it fits.
  function automatic logic [COORD_BITS-1:0] rem_step(
    input logic [COORD_BITS-1:0] rem,
    input logic                  nbit,
    input logic [DATA_W-1:0]     div
  );
    logic [WIDE_W-1:0] sh;
    logic [WIDE_W-1:0] dv;
    sh = WIDE_W'({rem, nbit});
    dv = {1'b0, div};
    if (sh >= dv) begin
      sh = sh - dv;
    end
    return sh[COORD_BITS-1:0];
  endfunction

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    a_sh_d = a_sh_q;
    b_sh_d = b_sh_q;
    ra_d   = ra_q;
    rb_d   = rb_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(COORD_BITS);
      a_sh_d = a_i;
      b_sh_d = b_i;
      ra_d   = '0;
      rb_d   = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      ra_d   = rem_step(ra_q, a_sh_q[COORD_BITS-1], div_q);
      rb_d   = rem_step(rb_q, b_sh_q[COORD_BITS-1], div_q);
      a_sh_d = a_sh_q << 1;
      b_sh_d = b_sh_q << 1;
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_sh_q <= a_sh_d;
    b_sh_q <= b_sh_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    div_q  <= div_d;
  end

  assign busy_o = busy_q;
  // zero spacing: nothing lies on a grid line
  assign a_zero_o = (ra_q == '0) && (div_q != '0);
  assign b_zero_o = (rb_q == '0) && (div_q != '0);

endmodule

FILE: rtl/gars_dp.sv
module gars_dp #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gars_pkg::in_word_t          in_data_i,
  input  logic                        cfg_valid_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [gars_pkg::DATA_W-1:0] cfg_data_i,
  input  gars_pkg::dp_cmd_t           cmd_i,
  output gars_pkg::dp_status_t        status_o,
  output gars_pkg::out_word_t         out_data_o
);
  import gars_pkg::*;

  localparam int unsigned CB = COORD_BITS;

  logic [DATA_W-1:0] spacing_q, line_color_q, back_color_q;

  logic          busy_q, busy_d;
  logic [3:0]    hdr_idx_q, hdr_idx_d;
  logic          low_half_q, low_half_d;
  logic [CB-1:0] left_q, left_d, top_q, top_d;
  logic [CB-1:0] width_q, width_d, height_q, height_d;
  logic [CB-1:0] cols_q, cols_d, rows_q, rows_d;
  out_word_t     out_q, out_d;

  logic          in_header;
  logic          empty_box;
  logic [CB-1:0] right, bottom, col, row;
  logic [DATA_W-1:0] right16, bottom16, left16, top16;
  logic          rem_busy, col_hit, row_hit;
  logic [DATA_W-1:0] color;
  logic [7:0]    hdr_byte;
  logic          hdr_rs;
  logic          col_end, row_end;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q    <= GRID_SPACING_RST;
      line_color_q <= LINE_COLOR_RST;
      back_color_q <= BACK_COLOR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_GRID_SPACING: spacing_q    <= cfg_data_i;
        REG_LINE_COLOR:   line_color_q <= cfg_data_i;
        REG_BACK_COLOR:   back_color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_header = (hdr_idx_q < HDR_LEN);
  assign empty_box = (width_q == '0) || (height_q == '0);
  assign right     = left_q + width_q - CB'(1);
  assign bottom    = top_q + height_q - CB'(1);
  assign left16    = DATA_W'(left_q);
  assign top16     = DATA_W'(top_q);
  assign right16   = DATA_W'(right);
  assign bottom16  = DATA_W'(bottom);
  assign col       = left_q + cols_q;
  assign row       = top_q + rows_q;

  gars_mod #(
    .COORD_BITS (COORD_BITS)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.rem_start),
    .a_i       (col),
    .b_i       (row),
    .divisor_i (spacing_q),
    .busy_o    (rem_busy),
    .a_zero_o  (col_hit),
    .b_zero_o  (row_hit)
  );

  assign color = (col_hit || row_hit) ? line_color_q : back_color_q;

  always_comb begin
    hdr_rs = RS_DATA;
    unique case (hdr_idx_q)
      HDR_COL_CMD: begin
        hdr_rs   = RS_COMMAND;
        hdr_byte = CMD_COLUMN_ADDR;
      end
      HDR_LEFT_HI:   hdr_byte = left16[15:8];
      HDR_LEFT_LO:   hdr_byte = left16[7:0];
      HDR_RIGHT_HI:  hdr_byte = right16[15:8];
      HDR_RIGHT_LO:  hdr_byte = right16[7:0];
      HDR_ROW_CMD: begin
        hdr_rs   = RS_COMMAND;
        hdr_byte = CMD_ROW_ADDR;
      end
      HDR_TOP_HI:    hdr_byte = top16[15:8];
      HDR_TOP_LO:    hdr_byte = top16[7:0];
      HDR_BOTTOM_HI: hdr_byte = bottom16[15:8];
      HDR_BOTTOM_LO: hdr_byte = bottom16[7:0];
      default: begin
        hdr_rs   = RS_COMMAND;
        hdr_byte = CMD_MEMORY_WRITE;
      end
    endcase
  end

  assign col_end = ({1'b0, cols_q} + (CB+1)'(1)) >= {1'b0, width_q};
  assign row_end = ({1'b0, rows_q} + (CB+1)'(1)) >= {1'b0, height_q};

  always_comb begin
    busy_d     = busy_q;
    hdr_idx_d  = hdr_idx_q;
    low_half_d = low_half_q;
    left_d     = left_q;
    top_d      = top_q;
    width_d    = width_q;
    height_d   = height_q;
    cols_d     = cols_q;
    rows_d     = rows_q;
    out_d      = out_q;
    if (cmd_i.load_start) begin
      busy_d     = 1'b1;
      hdr_idx_d  = HDR_COL_CMD;
      low_half_d = 1'b0;
      left_d     = in_data_i.left[CB-1:0];
      top_d      = in_data_i.top[CB-1:0];
      width_d    = in_data_i.box_width[CB-1:0];
      height_d   = in_data_i.box_height[CB-1:0];
      cols_d     = '0;
      rows_d     = '0;
    end else if (cmd_i.out_load) begin
      if (in_header) begin
        out_d.register_select = hdr_rs;
        out_d.bus_byte        = hdr_byte;
        out_d.last            = 1'b0;
        hdr_idx_d             = hdr_idx_q + 4'd1;
        if ((hdr_idx_q == HDR_MEM_CMD) && empty_box) begin
          out_d.last = 1'b1;
          busy_d     = 1'b0;
        end
      end else begin
        out_d.register_select = RS_DATA;
        out_d.last            = 1'b0;
        if (!low_half_q) begin
          out_d.bus_byte = color[15:8];
          low_half_d     = 1'b1;
        end else begin
          out_d.bus_byte = color[7:0];
          low_half_d     = 1'b0;
          if (col_end) begin
            cols_d = '0;
            if (row_end) begin
              out_d.last = 1'b1;
              busy_d     = 1'b0;
              rows_d     = '0;
            end else begin
              rows_d = rows_q + CB'(1);
            end
          end else begin
            cols_d = cols_q + CB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      hdr_idx_q  <= '0;
      low_half_q <= 1'b0;
      cols_q     <= '0;
      rows_q     <= '0;
    end else begin
      busy_q     <= busy_d;
      hdr_idx_q  <= hdr_idx_d;
      low_half_q <= low_half_d;
      cols_q     <= cols_d;
      rows_q     <= rows_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q   <= left_d;
    top_q    <= top_d;
    width_q  <= width_d;
    height_q <= height_d;
    out_q    <= out_d;
  end

  assign status_o.busy      = busy_q;
  assign status_o.in_header = in_header;
  assign status_o.rem_busy  = rem_busy;
  assign out_data_o         = out_q;

endmodule

FILE: rtl/gars_ctrl.sv
module gars_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_command_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  gars_pkg::dp_status_t status_i,
  output gars_pkg::dp_cmd_t    cmd_o
);
  import gars_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        tick_go;

  assign tick_go = in_valid_i && (in_command_i == OP_TICK) && status_i.busy;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (tick_go) begin
          state_d = status_i.in_header ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (!status_i.rem_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o.load_start = 1'b0;
    cmd_o.rem_start  = 1'b0;
    cmd_o.out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.load_start = in_valid_i && (in_command_i == OP_START) && !status_i.busy;
        cmd_o.rem_start  = tick_go && !status_i.in_header;
      end
      ST_DIV: ;
      ST_EMIT: cmd_o.out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/grid_area_restore_stream.sv
// A start word produces no output. A header tick passes through the emit state into the
//   output register; a pixel tick first passes the divide state, where the remainder unit runs.
// The remainder unit is bit-serial (one bit per cycle). A new tick is taken only after the
//   previous one has loaded its byte into the output register.
// Reset (async, active low): idle, no word pending, registers at spacing 40,
//   line color 13894, background color 0.
module grid_area_restore_stream #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  gars_pkg::in_word_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output gars_pkg::out_word_t         out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [gars_pkg::DATA_W-1:0] cfg_data_i
);
  import gars_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Config writes are registered directly; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  // Sequencer: accepts a word when idle, runs the remainder unit for
  // pixel bytes, then parks the result in the output register.
  gars_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_i     (dp_status),
    .cmd_o        (dp_cmd)
  );

  // Datapath: config registers, rectangle state, header byte mux, grid test, output register.
  gars_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_data_o  (out_data_o)
  );

endmodule
